// File: rtl/oven_timer_thermostat_controller_defines.svh
// assertion macros shared by the oven timer and thermostat controller
// no dependencies; included by the files that carry concurrent checks
`ifndef OVEN_TIMER_THERMOSTAT_CONTROLLER_DEFINES_SVH
`define OVEN_TIMER_THERMOSTAT_CONTROLLER_DEFINES_SVH

// condition holds at every edge out of reset
`define OTC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("otc check failed");

// consequence holds in the same cycle as the antecedent
`define OTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("otc check failed");

// consequence holds in the cycle after the antecedent
`define OTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("otc check failed");

`endif

// File: rtl/otc_pkg.sv
// shared constants and types of the oven timer and thermostat controller
// no dependencies
`default_nettype none

package otc_pkg;

    typedef logic [7:0] digit_t;

    // keypad codes and ascii digits
    localparam digit_t KEY_ENTER  = 8'h45;
    localparam digit_t KEY_BACK   = 8'h41;
    localparam digit_t KEY_NONE   = 8'h6E;
    localparam digit_t ASCII_ZERO = 8'h30;
    localparam digit_t ASCII_ONE  = 8'h31;
    localparam digit_t ASCII_TWO  = 8'h32;
    localparam digit_t ASCII_FIVE = 8'h35;
    localparam digit_t ASCII_SIX  = 8'h36;
    localparam digit_t ASCII_NINE = 8'h39;

    localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
    localparam logic [2:0] LAST_PLACE         = 3'd5;
    localparam logic [2:0] PLACE_LIMIT        = 3'd6;

    // x/9 for 12-bit x as (x * 3641) >> 15, exact over the whole range
    localparam logic [11:0] DIV9_RECIP = 12'd3641;
    localparam int          PROD_W     = 24;
    localparam int          DIV9_SHIFT = 15;
    localparam int          SENSOR_W   = PROD_W - DIV9_SHIFT;

    // ascii bias of three weighted digits: 0x30 * 111
    localparam logic [15:0] SET_BIAS = 16'd5328;

    typedef enum logic [1:0] {
        CMD_KEY    = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_IDLE   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  key_code;
        logic [11:0] adc_sample;
    } item_t;

    typedef struct packed {
        logic       heater_on;
        logic       finished;
        digit_t     min_hundreds;
        digit_t     min_tens;
        digit_t     min_ones;
        digit_t     set_hundreds;
        digit_t     set_tens;
        digit_t     set_ones;
        logic [5:0] seconds_left;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/otc_item_if.sv
// input channel of the oven controller: command, key and converter reading
// no dependencies
`default_nettype none

interface otc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  key_code;
    logic [11:0] adc_sample;

    modport source (output valid, output command, output key_code, output adc_sample,
                    input ready);
    modport sink   (input valid, input command, input key_code, input adc_sample,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/otc_result_if.sv
// result channel of the oven controller: heater, done and display digits
// no dependencies
`default_nettype none

interface otc_result_if;
    logic       valid;
    logic       ready;
    logic       heater_on;
    logic       finished;
    logic [7:0] min_hundreds;
    logic [7:0] min_tens;
    logic [7:0] min_ones;
    logic [7:0] set_hundreds;
    logic [7:0] set_tens;
    logic [7:0] set_ones;
    logic [5:0] seconds_left;

    modport source (output valid, output heater_on, output finished,
                    output min_hundreds, output min_tens, output min_ones,
                    output set_hundreds, output set_tens, output set_ones,
                    output seconds_left, input ready);
    modport sink   (input valid, input heater_on, input finished,
                    input min_hundreds, input min_tens, input min_ones,
                    input set_hundreds, input set_tens, input set_ones,
                    input seconds_left, output ready);
endinterface

`default_nettype wire

// File: rtl/otc_sensor.sv
// temperature compare: converter reading / 9 + 1 against the ascii setpoint
// depends on otc_pkg
`default_nettype none

module otc_sensor
    import otc_pkg::*;
(
    input  logic [11:0] adc_sample,
    input  digit_t      set_hundreds,
    input  digit_t      set_tens,
    input  digit_t      set_ones,
    output logic        heat_demand
);

    logic [PROD_W-1:0]   product;
    logic [SENSOR_W-1:0] sensor;
    logic [15:0]         weighted;
    logic [15:0]         target;

    // reciprocal multiply for the divide by nine
    assign product = PROD_W'(adc_sample) * PROD_W'(DIV9_RECIP);
    assign sensor  = product[PROD_W-1:DIV9_SHIFT] + SENSOR_W'(1);

    // setpoint value modulo 2^16, digits taken as raw codes
    assign weighted = 16'(set_hundreds) * 16'd100 + 16'(set_tens) * 16'd10
                    + 16'(set_ones);
    assign target   = weighted - SET_BIAS;

    assign heat_demand = 16'(sensor) < target;

endmodule

`default_nettype wire

// File: rtl/otc_core.sv
// controller state and its next-state update for one item
// depends on otc_pkg, otc_sensor and the assertion macro header
`default_nettype none
`include "oven_timer_thermostat_controller_defines.svh"

module otc_core
    import otc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output result_t view_next
);

    digit_t [2:0] min_reg, min_next;
    digit_t [2:0] set_reg, set_next;
    logic [2:0]   pos_reg, pos_next;
    logic [5:0]   sc_reg, sc_next;
    logic         hot_reg, hot_next;
    logic         count_reg, count_next;
    logic         done_reg, done_next;
    logic         heat_reg, heat_next;

    logic [2:0]   place;
    logic         heat_demand;
    logic         tick_on_done;

    otc_sensor u_sensor (
        .adc_sample   (item.adc_sample),
        .set_hundreds (set_reg[0]),
        .set_tens     (set_reg[1]),
        .set_ones     (set_reg[2]),
        .heat_demand  (heat_demand)
    );

    // next state for the item in the input register
    always_comb
    begin
        min_next   = min_reg;
        set_next   = set_reg;
        pos_next   = pos_reg;
        sc_next    = sc_reg;
        hot_next   = hot_reg;
        count_next = count_reg;
        done_next  = done_reg;
        heat_next  = heat_reg;
        place      = (pos_reg > LAST_PLACE) ? 3'd0 : pos_reg;
        case (item.command)
            CMD_KEY:
            begin
                if (item.key_code == KEY_ENTER)
                begin
                    count_next = 1'b1;
                    // enter after done restarts the timer
                    if (done_reg)
                    begin
                        pos_next  = 3'd0;
                        sc_next   = SECONDS_PER_MINUTE;
                        hot_next  = 1'b0;
                        min_next  = {ASCII_ZERO, ASCII_ZERO, ASCII_ZERO};
                        done_next = 1'b0;
                    end
                end
                else if (item.key_code == KEY_BACK)
                begin
                    if (pos_reg != 3'd0)
                        pos_next = pos_reg - 3'd1;
                end
                else if (item.key_code != KEY_NONE)
                begin
                    // any other code lands in the current place
                    case (place)
                        3'd0:    min_next[0] = item.key_code;
                        3'd1:    min_next[1] = item.key_code;
                        3'd2:    min_next[2] = item.key_code;
                        3'd3:    set_next[0] = item.key_code;
                        3'd4:    set_next[1] = item.key_code;
                        default: set_next[2] = item.key_code;
                    endcase
                    pos_next = place + 3'd1;
                end
            end
            CMD_TICK:
            begin
                if (!done_reg && count_reg && hot_reg)
                begin
                    // seconds then minutes with decimal borrow
                    sc_next = sc_reg - 6'd1;
                    if (sc_next == 6'd0)
                    begin
                        sc_next     = SECONDS_PER_MINUTE;
                        min_next[2] = min_reg[2] - 8'd1;
                    end
                    if (min_next[2] < ASCII_ZERO)
                    begin
                        min_next[2] = ASCII_NINE;
                        min_next[1] = min_reg[1] - 8'd1;
                    end
                    if (min_reg[0] != ASCII_ZERO && min_next[1] < ASCII_ZERO)
                    begin
                        min_next[1] = ASCII_NINE;
                        min_next[0] = min_reg[0] - 8'd1;
                    end
                    if (min_next[0] == ASCII_ZERO && min_next[1] == ASCII_ZERO
                        && min_next[2] == ASCII_ZERO)
                    begin
                        done_next = 1'b1;
                        heat_next = 1'b0;
                    end
                    // setpoint forced to 25x when hundreds is at least 2 and tens at least 5
                    if (set_reg[0] >= ASCII_TWO && set_reg[1] >= ASCII_FIVE)
                    begin
                        set_next[0] = ASCII_TWO;
                        set_next[1] = ASCII_FIVE;
                    end
                end
            end
            CMD_SAMPLE:
            begin
                if (heat_demand)
                    heat_next = 1'b1;
                else
                begin
                    heat_next = 1'b0;
                    hot_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= {ASCII_ZERO, ASCII_TWO, ASCII_ONE};
            set_reg   <= {ASCII_SIX, ASCII_ZERO, ASCII_TWO};
            pos_reg   <= 3'd0;
            sc_reg    <= SECONDS_PER_MINUTE;
            hot_reg   <= 1'b0;
            count_reg <= 1'b0;
            done_reg  <= 1'b0;
            heat_reg  <= 1'b0;
        end
        else if (step)
        begin
            min_reg   <= min_next;
            set_reg   <= set_next;
            pos_reg   <= pos_next;
            sc_reg    <= sc_next;
            hot_reg   <= hot_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            heat_reg  <= heat_next;
        end
    end

    // result view of the updated state
    assign view_next = '{
        heater_on:    heat_next && !done_next,
        finished:     done_next,
        min_hundreds: min_next[0],
        min_tens:     min_next[1],
        min_ones:     min_next[2],
        set_hundreds: set_next[0],
        set_tens:     set_next[1],
        set_ones:     set_next[2],
        seconds_left: sc_next
    };

    // tick taken while the countdown is finished
    assign tick_on_done = step && item.command == CMD_TICK && done_reg;

    // checks
    `OTC_ASSERT_ALWAYS(a_pos_range, clk, rst_n, pos_reg <= PLACE_LIMIT)
    `OTC_ASSERT_ALWAYS(a_sec_range, clk, rst_n, sc_reg != 6'd0 && sc_reg <= SECONDS_PER_MINUTE)
    `OTC_ASSERT_NEXT(a_done_freeze, clk, rst_n, tick_on_done, $stable({min_reg, sc_reg}) && done_reg)
    `OTC_ASSERT_NEXT(a_hold_idle, clk, rst_n, !step, $stable({min_reg, set_reg, pos_reg, sc_reg}))

endmodule

`default_nettype wire

// File: rtl/oven_timer_thermostat_controller.sv
// top level of the oven timer and thermostat controller
// depends on otc_pkg, otc_item_if, otc_result_if and otc_core
//
//   channel  | dir | payload
//   ---------+-----+-------------------------------------------------
//   item     | in  | command, key_code, adc_sample
//   result   | out | heater_on, finished, minute and setpoint digits,
//            |     | seconds_left
//
// one beat in, one beat out; a new item is taken every cycle unless the result side stalls
// an item passes the input register, then the state update into the result register
// the result register stalls on result.ready and the input register holds one item
// behind it, so item.ready drops only when both are full
// reset is asynchronous and restores timer 120 min, setpoint 206, heater off
`default_nettype none

module oven_timer_thermostat_controller
    import otc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    otc_item_if.sink        item,
    otc_result_if.source    result
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t view_next;
    logic    advance;

    // move the held item into the result register
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item.ready)
            in_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            in_item_reg <= '{
                command:    cmd_t'(item.command),
                key_code:   item.key_code,
                adc_sample: item.adc_sample
            };
    end

    otc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .view_next (view_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= view_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.heater_on    = out_reg.heater_on;
    assign result.finished     = out_reg.finished;
    assign result.min_hundreds = out_reg.min_hundreds;
    assign result.min_tens     = out_reg.min_tens;
    assign result.min_ones     = out_reg.min_ones;
    assign result.set_hundreds = out_reg.set_hundreds;
    assign result.set_tens     = out_reg.set_tens;
    assign result.set_ones     = out_reg.set_ones;
    assign result.seconds_left = out_reg.seconds_left;

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for the oven timer and thermostat controller: a directed table,
// then random keypad sessions, checked beat by beat against an in-bench state predictor
// depends on otc_pkg, otc_item_if, otc_result_if and oven_timer_thermostat_controller
`timescale 1ns / 100ps

module tb_top;
    import otc_pkg::*;

    localparam int ITEM_COUNT     = 650;
    localparam int LONG_HOLD      = 60;
    localparam int TAIL_CYCLES    = 8;
    // longest quiet stretch is the long hold plus a long sender gap, with wide margin
    localparam int WATCHDOG_LIMIT = 2000;

    localparam result_t AT_RESET = '{1'b0, 1'b0, ASCII_ONE, ASCII_TWO, ASCII_ZERO,
                                     ASCII_TWO, ASCII_ZERO, ASCII_SIX, SECONDS_PER_MINUTE};
    localparam result_t COLD_HEATING = '{1'b1, 1'b0, ASCII_ONE, ASCII_TWO, ASCII_ZERO,
                                         ASCII_TWO, ASCII_ZERO, ASCII_SIX, SECONDS_PER_MINUTE};

    typedef struct {
        item_t   beat;
        bit      typed;
        result_t want;
    } plan_row_t;

    logic clk;
    logic rst_n;

    otc_item_if   item_ch ();
    otc_result_if result_ch ();

    oven_timer_thermostat_controller i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // predicted controller state
    digit_t     mins [3];
    digit_t     setp [3];
    logic [2:0] place;
    logic [5:0] secs;
    bit         hot;
    bit         counting;
    bit         timer_done;
    bit         heat;

    result_t    expected_q [$];
    plan_row_t  plan_q [$];
    int         mismatches  = 0;
    int         accepted    = 0;
    int         idle_cycles = 0;
    bit         quiet       = 1'b0;
    bit         hold_wanted = 1'b0;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // apply one beat to the predicted state and return what the display shows after it
    function automatic result_t oven_step(input item_t b);
        result_t    r;
        int         set_val;
        int         sensor;
        logic [15:0] target;
        case (b.command)
            CMD_KEY:
            begin
                if (b.key_code == KEY_ENTER)
                begin
                    counting = 1'b1;
                    // enter after completion restarts with zero minutes
                    if (timer_done)
                    begin
                        place      = '0;
                        secs       = SECONDS_PER_MINUTE;
                        hot        = 1'b0;
                        mins       = '{ASCII_ZERO, ASCII_ZERO, ASCII_ZERO};
                        timer_done = 1'b0;
                    end
                end
                else if (b.key_code == KEY_BACK)
                begin
                    if (place != 3'd0)
                        place = place - 3'd1;
                end
                else if (b.key_code != KEY_NONE)
                begin
                    // any other code is stored as is, position wraps after the last place
                    if (place > LAST_PLACE)
                        place = '0;
                    if (place > 3'd2)
                        setp[place - 3'd3] = b.key_code;
                    else
                        mins[place] = b.key_code;
                    place = place + 3'd1;
                end
            end
            CMD_TICK:
            begin
                if (!timer_done && counting && hot)
                begin
                    secs = secs - 6'd1;
                    if (secs == 6'd0)
                    begin
                        secs    = SECONDS_PER_MINUTE;
                        mins[2] = mins[2] - 8'd1;
                    end
                    // decimal borrow through the minute digits
                    if (mins[2] < ASCII_ZERO)
                    begin
                        mins[2] = ASCII_NINE;
                        mins[1] = mins[1] - 8'd1;
                    end
                    if (mins[0] != ASCII_ZERO && mins[1] < ASCII_ZERO)
                    begin
                        mins[1] = ASCII_NINE;
                        mins[0] = mins[0] - 8'd1;
                    end
                    if (mins[0] == ASCII_ZERO && mins[1] == ASCII_ZERO && mins[2] == ASCII_ZERO)
                    begin
                        timer_done = 1'b1;
                        heat       = 1'b0;
                    end
                    // setpoint forced to 25x when hundreds is at least 2 and tens at least 5
                    if (setp[0] >= ASCII_TWO && setp[1] >= ASCII_FIVE)
                    begin
                        setp[0] = ASCII_TWO;
                        setp[1] = ASCII_FIVE;
                    end
                end
            end
            CMD_SAMPLE:
            begin
                sensor  = b.adc_sample / 9 + 1;
                set_val = (int'(setp[0]) - int'(ASCII_ZERO)) * 100
                        + (int'(setp[1]) - int'(ASCII_ZERO)) * 10
                        + (int'(setp[2]) - int'(ASCII_ZERO));
                target  = set_val[15:0];
                if (sensor < int'(target))
                    heat = 1'b1;
                else
                begin
                    heat = 1'b0;
                    hot  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.heater_on    = heat && !timer_done;
        r.finished     = timer_done;
        r.min_hundreds = mins[0];
        r.min_tens     = mins[1];
        r.min_ones     = mins[2];
        r.set_hundreds = setp[0];
        r.set_tens     = setp[1];
        r.set_ones     = setp[2];
        r.seconds_left = secs;
        return r;
    endfunction

    // gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_row(input cmd_t c, input digit_t k, input logic [11:0] a,
                                    input bit typed, input result_t w);
        plan_row_t row;
        row.beat  = '{c, k, a};
        row.typed = typed;
        row.want  = w;
        plan_q.push_back(row);
    endfunction

    // offer one beat, wait for acceptance, then queue its expected result
    task automatic offer(input item_t b, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.command    <= b.command;
        item_ch.key_code   <= b.key_code;
        item_ch.adc_sample <= b.adc_sample;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        predicted = oven_step(b);
        expected_q.push_back(typed ? want : predicted);
        accepted++;
    endtask

    task automatic send_item(input cmd_t c, input digit_t k, input logic [11:0] a);
        offer('{c, k, a}, 1'b0, '0);
    endtask

    // one keypad session: maybe enter, clear back, six places, enter, one sample, then a countdown run
    task automatic run_session();
        digit_t m [3];
        digit_t s [3];
        digit_t k;
        int     r;
        quiet = ($urandom_range(0, 3) == 0);
        if (timer_done || $urandom_range(0, 4) == 0)
            send_item(CMD_KEY, KEY_ENTER, 12'($urandom_range(0, 4095)));
        repeat (place) send_item(CMD_KEY, KEY_BACK, 12'($urandom_range(0, 4095)));

        // minute patterns that finish at once, after a minute, or borrow across digits
        case ($urandom_range(0, 5))
            0: m = '{ASCII_ZERO, ASCII_ZERO, ASCII_ZERO};
            1: m = '{ASCII_ZERO, ASCII_ZERO, ASCII_ONE};
            2: m = '{ASCII_ZERO, ASCII_ONE, ASCII_ZERO};
            3: m = '{ASCII_ONE, ASCII_ZERO, ASCII_ZERO};
            default:
                foreach (m[i])
                    m[i] = ASCII_ZERO + digit_t'($urandom_range(0, 9));
        endcase
        s[0] = ASCII_ZERO + digit_t'($urandom_range(0, 3));
        s[1] = ASCII_ZERO + digit_t'($urandom_range(0, 9));
        s[2] = ASCII_ZERO + digit_t'($urandom_range(0, 9));
        foreach (s[i])
            if ($urandom_range(0, 7) == 0)
                s[i] = digit_t'($urandom_range(0, 255));

        for (int i = 0; i < 6; i++)
        begin
            k = (i < 3) ? m[i] : s[i - 3];
            if ($urandom_range(0, 11) == 0)
                k = digit_t'($urandom_range(0, 255));
            send_item(CMD_KEY, k, 12'($urandom_range(0, 4095)));
        end
        send_item(CMD_KEY, KEY_ENTER, 12'($urandom_range(0, 4095)));
        send_item(CMD_SAMPLE, digit_t'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));

        // countdown with samples, stray keys and empty commands mixed in
        repeat ($urandom_range(1, 90))
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_item(CMD_TICK, digit_t'($urandom_range(0, 255)),
                          12'($urandom_range(0, 4095)));
            else if (r < 85)
                send_item(CMD_SAMPLE, digit_t'($urandom_range(0, 255)),
                          12'($urandom_range(0, 4095)));
            else if (r < 95)
                send_item(CMD_KEY, digit_t'($urandom_range(0, 255)),
                          12'($urandom_range(0, 4095)));
            else
                send_item(CMD_IDLE, digit_t'($urandom_range(0, 255)),
                          12'($urandom_range(0, 4095)));
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        int session;
        item_ch.valid      = 1'b0;
        item_ch.command    = CMD_IDLE;
        item_ch.key_code   = KEY_NONE;
        item_ch.adc_sample = '0;
        rst_n              = 1'b0;
        mins       = '{ASCII_ONE, ASCII_TWO, ASCII_ZERO};
        setp       = '{ASCII_TWO, ASCII_ZERO, ASCII_SIX};
        place      = '0;
        secs       = SECONDS_PER_MINUTE;
        hot        = 1'b0;
        counting   = 1'b0;
        timer_done = 1'b0;
        heat       = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty command, tick before enter, no key, back at place 0: all show reset state
        add_row(CMD_IDLE,   8'hFF,             12'hFFF, 1'b1, AT_RESET);
        add_row(CMD_TICK,   8'h00,             12'h000, 1'b1, AT_RESET);
        add_row(CMD_KEY,    KEY_NONE,          12'h000, 1'b1, AT_RESET);
        add_row(CMD_KEY,    KEY_BACK,          12'h000, 1'b1, AT_RESET);
        // coldest reading heats, hottest reading marks the oven hot
        add_row(CMD_SAMPLE, 8'h00,             12'h000, 1'b1, COLD_HEATING);
        add_row(CMD_SAMPLE, 8'h00,             12'hFFF, 1'b1, AT_RESET);
        // hot but not counting: tick ignored
        add_row(CMD_TICK,   8'h00,             12'h000, 1'b1, AT_RESET);
        // minutes 000, setpoint hundreds below ascii zero, then back one place
        add_row(CMD_KEY,    ASCII_ZERO,        12'h000, 1'b0, '0);
        add_row(CMD_KEY,    ASCII_ZERO,        12'h000, 1'b0, '0);
        add_row(CMD_KEY,    ASCII_ZERO,        12'h000, 1'b0, '0);
        add_row(CMD_KEY,    8'h00,             12'h000, 1'b0, '0);
        add_row(CMD_KEY,    KEY_BACK,          12'h000, 1'b0, '0);
        // setpoint sum wraps negative
        add_row(CMD_SAMPLE, 8'h00,             12'hFFF, 1'b0, '0);
        add_row(CMD_KEY,    ASCII_ZERO + 8'd3, 12'h000, 1'b0, '0);
        add_row(CMD_KEY,    ASCII_NINE,        12'h000, 1'b0, '0);
        add_row(CMD_KEY,    8'hFF,             12'h000, 1'b0, '0);
        // position wraps back to the first place
        add_row(CMD_KEY,    ASCII_ZERO,        12'h000, 1'b0, '0);
        add_row(CMD_KEY,    KEY_ENTER,         12'h000, 1'b0, '0);
        add_row(CMD_SAMPLE, 8'h00,             12'hFFF, 1'b0, '0);
        // first tick clamps the setpoint and finishes, second is ignored
        add_row(CMD_TICK,   8'h00,             12'h000, 1'b0, '0);
        add_row(CMD_TICK,   8'h00,             12'h000, 1'b0, '0);
        // heater held off while finished, then restart
        add_row(CMD_SAMPLE, 8'h00,             12'h000, 1'b0, '0);
        add_row(CMD_KEY,    KEY_ENTER,         12'h000, 1'b0, '0);
        add_row(CMD_SAMPLE, 8'h00,             12'h000, 1'b0, '0);

        foreach (plan_q[i])
            offer(plan_q[i].beat, plan_q[i].typed, plan_q[i].want);

        // sender pause until everything has drained
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);

        // random sessions, the second one with a long result-side hold
        session = 0;
        while (accepted < ITEM_COUNT)
        begin
            if (session == 1)
                hold_wanted = 1'b1;
            run_session();
            session++;
        end

        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[oven_timer_thermostat_controller] OK");
        else
            $display("[oven_timer_thermostat_controller] ERROR");
        $finish;
    end

    // result side ready with random stalls and one long hold
    initial
    begin : result_sink
        int stall;
        result_ch.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_wanted)
            begin
                stall       = LONG_HOLD;
                hold_wanted = 1'b0;
            end
            else if (quiet)
                stall = 0;
            else
                stall = idle_len();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got = {result_ch.heater_on, result_ch.finished,
                   result_ch.min_hundreds, result_ch.min_tens, result_ch.min_ones,
                   result_ch.set_hundreds, result_ch.set_tens, result_ch.set_ones,
                   result_ch.seconds_left};
            if (expected_q.size() == 0)
            begin
                $error("result beat with no prediction pending");
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("heater_on",    got.heater_on,    want.heater_on);
                check_field("finished",     got.finished,     want.finished);
                check_field("min_hundreds", got.min_hundreds, want.min_hundreds);
                check_field("min_tens",     got.min_tens,     want.min_tens);
                check_field("min_ones",     got.min_ones,     want.min_ones);
                check_field("set_hundreds", got.set_hundreds, want.set_hundreds);
                check_field("set_tens",     got.set_tens,     want.set_tens);
                check_field("set_ones",     got.set_ones,     want.set_ones);
                check_field("seconds_left", got.seconds_left, want.seconds_left);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin : stall_watch
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("[oven_timer_thermostat_controller] ERROR");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/otc_pkg.sv
rtl/otc_item_if.sv
rtl/otc_result_if.sv
rtl/otc_sensor.sv
rtl/otc_core.sv
rtl/oven_timer_thermostat_controller.sv
bench/tb_top.sv
